### src/mcif_pkg.sv
`timescale 1ns / 1ps
package mcif_pkg;

    localparam int HIST_W   = 40;
    localparam int ACC_W    = 48;
    localparam int COEF_W   = 32;
    localparam int SAMPLE_W = 24;
    localparam int OUT_W    = 32;
    localparam int PROD_W   = 53;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_SEC,
        S_LOAD,
        S_EXEC,
        S_COMMIT,
        S_WB,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        REG_MODE,
        REG_COEF_A,
        REG_COEF_B,
        REG_COEF_C,
        REG_COEF_D,
        REG_COEF_E,
        REG_GALV_GAIN,
        REG_GALV_FB
    } t_reg;

    typedef enum logic [3:0] {
        SRC_IH0, SRC_IH1, SRC_IH2, SRC_IH3,
        SRC_OH0, SRC_OH1, SRC_OH2, SRC_OH3,
        SRC_Y, SRC_T, SRC_V, SRC_U
    } t_src;

    typedef enum logic [2:0] {
        CF_A, CF_B, CF_C, CF_D, CF_E, CF_G, CF_G1, CF_G2
    } t_coef;

    typedef enum logic {
        K_MAC,
        K_ADD
    } t_kind;

    typedef enum logic [1:0] {
        SV_NONE,
        SV_T,
        SV_V,
        SV_U
    } t_save;

    typedef enum logic [1:0] {
        PH_LO,
        PH_HI,
        PH_ACC
    } t_phase;

    typedef struct packed {
        t_src  src;
        t_coef coef;
        t_kind kind;
        logic  neg;
        logic  dbl;
        t_save save;
        logic  last;
    } t_op;

    typedef struct packed {
        logic   en;
        t_phase phase;
        t_kind  kind;
        logic   neg;
        logic   dbl;
        logic   clear;
    } t_mac_ctl;

    function automatic t_op mk_op(t_src s, t_coef c, t_kind k, logic n, logic d,
                                  t_save sv, logic l);
        t_op o;
        o.src  = s;
        o.coef = c;
        o.kind = k;
        o.neg  = n;
        o.dbl  = d;
        o.save = sv;
        o.last = l;
        return o;
    endfunction

    // simulation cascade when sim is set, otherwise one bandpass section
    function automatic t_op op_lookup(logic sim, logic [3:0] pc);
        t_op o;
        o = mk_op(SRC_Y, CF_A, K_ADD, 1'b0, 1'b0, SV_NONE, 1'b1);
        if (sim) begin
            unique case (pc)
                4'd0:  o = mk_op(SRC_IH0, CF_B, K_MAC, 1'b0, 1'b0, SV_NONE, 1'b0);
                4'd1:  o = mk_op(SRC_IH1, CF_C, K_MAC, 1'b0, 1'b0, SV_NONE, 1'b0);
                4'd2:  o = mk_op(SRC_Y, CF_A, K_MAC, 1'b0, 1'b0, SV_NONE, 1'b0);
                4'd3:  o = mk_op(SRC_OH0, CF_D, K_MAC, 1'b1, 1'b0, SV_NONE, 1'b0);
                4'd4:  o = mk_op(SRC_OH1, CF_E, K_MAC, 1'b1, 1'b0, SV_V, 1'b0);
                4'd5:  o = mk_op(SRC_V, CF_A, K_ADD, 1'b0, 1'b0, SV_NONE, 1'b0);
                4'd6:  o = mk_op(SRC_OH0, CF_A, K_ADD, 1'b0, 1'b1, SV_NONE, 1'b0);
                4'd7:  o = mk_op(SRC_OH1, CF_A, K_ADD, 1'b0, 1'b0, SV_T, 1'b0);
                4'd8:  o = mk_op(SRC_T, CF_G, K_MAC, 1'b0, 1'b0, SV_NONE, 1'b0);
                4'd9:  o = mk_op(SRC_OH2, CF_G1, K_MAC, 1'b1, 1'b0, SV_NONE, 1'b0);
                4'd10: o = mk_op(SRC_OH3, CF_G2, K_MAC, 1'b1, 1'b0, SV_U, 1'b1);
                default: o = mk_op(SRC_Y, CF_A, K_ADD, 1'b0, 1'b0, SV_NONE, 1'b1);
            endcase
        end else begin
            unique case (pc)
                4'd0: o = mk_op(SRC_IH3, CF_A, K_ADD, 1'b0, 1'b0, SV_NONE, 1'b0);
                4'd1: o = mk_op(SRC_Y, CF_A, K_ADD, 1'b0, 1'b0, SV_NONE, 1'b0);
                4'd2: o = mk_op(SRC_IH1, CF_A, K_ADD, 1'b1, 1'b1, SV_T, 1'b0);
                4'd3: o = mk_op(SRC_T, CF_A, K_MAC, 1'b0, 1'b0, SV_NONE, 1'b0);
                4'd4: o = mk_op(SRC_OH0, CF_B, K_MAC, 1'b1, 1'b0, SV_NONE, 1'b0);
                4'd5: o = mk_op(SRC_OH1, CF_C, K_MAC, 1'b1, 1'b0, SV_NONE, 1'b0);
                4'd6: o = mk_op(SRC_OH2, CF_D, K_MAC, 1'b1, 1'b0, SV_NONE, 1'b0);
                4'd7: o = mk_op(SRC_OH3, CF_E, K_MAC, 1'b1, 1'b0, SV_V, 1'b1);
                default: o = mk_op(SRC_Y, CF_A, K_ADD, 1'b0, 1'b0, SV_NONE, 1'b1);
            endcase
        end
        return o;
    endfunction

    function automatic logic signed [HIST_W-1:0] sat40(logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'((64'sd1 <<< (HIST_W - 1)) - 64'sd1);
        lo = -ACC_W'(64'sd1 <<< (HIST_W - 1));
        if (v > hi) begin
            return hi[HIST_W-1:0];
        end else if (v < lo) begin
            return lo[HIST_W-1:0];
        end
        return v[HIST_W-1:0];
    endfunction

endpackage

### src/mcif_mac.sv
`timescale 1ns / 1ps
module mcif_mac (
    input  logic                                  i_clk,
    input  mcif_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [mcif_pkg::COEF_W-1:0]    i_coef,
    input  logic signed [mcif_pkg::HIST_W-1:0]    i_opnd,
    output logic signed [mcif_pkg::ACC_W-1:0]     o_sum
);

    localparam int FULL_W = mcif_pkg::PROD_W + 21;

    logic signed [20:0]                     mul_b;
    logic signed [mcif_pkg::PROD_W-1:0]     prod;
    logic signed [mcif_pkg::PROD_W-1:0]     r_plo;
    logic signed [mcif_pkg::PROD_W-1:0]     r_phi;
    logic signed [mcif_pkg::ACC_W-1:0]      r_acc;
    logic signed [FULL_W-1:0]               full;
    logic signed [FULL_W-1:0]               rnd;
    logic signed [mcif_pkg::ACC_W-1:0]      term;

    always_comb begin
        if (i_ctl.phase == mcif_pkg::PH_LO) begin
            mul_b = $signed({1'b0, i_opnd[19:0]});
        end else begin
            mul_b = 21'($signed(i_opnd[39:20]));
        end
        prod = i_coef * mul_b;
    end

    always_comb begin
        full = (FULL_W'(r_phi) <<< 20) + FULL_W'(r_plo) + (FULL_W'(1) <<< 27);
        rnd  = full >>> 28;
        if (i_ctl.kind == mcif_pkg::K_MAC) begin
            term = rnd[mcif_pkg::ACC_W-1:0];
        end else if (i_ctl.dbl) begin
            term = mcif_pkg::ACC_W'(i_opnd) <<< 1;
        end else begin
            term = mcif_pkg::ACC_W'(i_opnd);
        end
        if (i_ctl.neg) begin
            o_sum = r_acc - term;
        end else begin
            o_sum = r_acc + term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en && i_ctl.phase == mcif_pkg::PH_LO) begin
            r_plo <= prod;
        end
        if (i_ctl.en && i_ctl.phase == mcif_pkg::PH_HI) begin
            r_phi <= prod;
        end
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.en && i_ctl.phase == mcif_pkg::PH_ACC) begin
            r_acc <= o_sum;
        end
    end

endmodule

### src/multichannel_cascaded_iir_filter.sv
`timescale 1ns / 1ps
// An out-of-range channel skips the sections. Mode 0 runs one simulation
// section, modes 1 to 3 run min(mode, SECTIONS) bandpass sections; restart
// also clears untouched sections. One item at a time; the one shared 32x21
// multiplier does each coefficient term in lo, hi and accumulate phases.
// Reset is synchronous; then a clearing pass over CHANNELS*SECTIONS*4 entries
// zeroes the history memories before the first input transfer.
module multichannel_cascaded_iir_filter #(
    parameter int CHANNELS = 32,
    parameter int SECTIONS = 2
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [4:0]                            i_channel,
    input  logic                                  i_restart,
    input  logic signed [mcif_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [mcif_pkg::OUT_W-1:0]     o_filtered,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [5:0]                            paddr,
    input  logic [63:0]                           pwdata,
    output logic [63:0]                           prdata,
    output logic                                  pready
);

    localparam int ROWS  = CHANNELS * SECTIONS;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int AW    = RW + 2;
    localparam int DEPTH = ROWS * 4;
    localparam int SW    = $clog2(SECTIONS + 1);
    localparam int HW    = mcif_pkg::HIST_W;

    mcif_pkg::t_state r_state;
    mcif_pkg::t_state n_state;

    logic [1:0]         r_mode;
    logic signed [31:0] r_ca, r_cb, r_cc, r_cd, r_ce, r_gg;
    logic [63:0]        r_gfb;

    logic               r_restart;
    logic [RW-1:0]      r_base;
    logic [SW-1:0]      r_sec;
    logic [2:0]         r_j;
    logic [3:0]         r_pc;
    mcif_pkg::t_phase   r_ph;
    logic [AW-1:0]      r_clr;

    logic signed [HW-1:0] r_ih [4];
    logic signed [HW-1:0] r_oh [4];
    logic signed [HW-1:0] r_y, r_t, r_v, r_u;
    logic signed [mcif_pkg::OUT_W-1:0] r_out;

    logic signed [HW-1:0] mem_ih [DEPTH];
    logic signed [HW-1:0] mem_oh [DEPTH];
    logic signed [HW-1:0] r_ih_rd;
    logic signed [HW-1:0] r_oh_rd;

    logic [RW-1:0]      row;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    logic signed [HW-1:0] wr_ih, wr_oh;

    logic               in_xfer;
    logic               oor;
    logic               active;
    logic               sec_done;
    logic               sim;
    logic [1:0]         ld_idx;
    logic               cfg_wr;
    mcif_pkg::t_reg     cfg_idx;

    mcif_pkg::t_op      op;
    mcif_pkg::t_mac_ctl mac_ctl;
    logic signed [31:0] coef;
    logic signed [HW-1:0] opnd;
    logic signed [mcif_pkg::ACC_W-1:0] sum;
    logic signed [HW-1:0] sum_sat;

    logic signed [HW:0]   rsum;
    logic signed [HW:0]   rsh;
    logic signed [mcif_pkg::OUT_W-1:0] y_out;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = mcif_pkg::t_reg'(paddr[5:3]);

    assign o_stall    = (r_state != mcif_pkg::S_IDLE);
    assign o_valid    = (r_state == mcif_pkg::S_OUT);
    assign o_filtered = r_out;
    assign in_xfer    = i_valid && !o_stall;
    assign oor        = int'(i_channel) >= CHANNELS;
    assign sim        = (r_mode == 2'd0);

    always_comb begin
        int nact;
        if (r_mode == 2'd0) begin
            nact = 1;
        end else if (int'(r_mode) > SECTIONS) begin
            nact = SECTIONS;
        end else begin
            nact = int'(r_mode);
        end
        active   = int'(r_sec) < nact;
        sec_done = (int'(r_sec) >= SECTIONS) || (!active && !r_restart);
    end

    assign row     = r_base + RW'(r_sec);
    assign rd_addr = {row, r_j[1:0]};
    assign ld_idx  = r_j[1:0] - 2'd1;

    always_comb begin
        if (r_state == mcif_pkg::S_CLR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr;
            wr_ih   = '0;
            wr_oh   = '0;
        end else begin
            wr_en   = (r_state == mcif_pkg::S_WB);
            wr_addr = {row, r_j[1:0]};
            wr_ih   = r_ih[r_j[1:0]];
            wr_oh   = r_oh[r_j[1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_ih[wr_addr] <= wr_ih;
            mem_oh[wr_addr] <= wr_oh;
        end
        r_ih_rd <= mem_ih[rd_addr];
        r_oh_rd <= mem_oh[rd_addr];
    end

    always_comb begin
        op = mcif_pkg::op_lookup(sim, r_pc);
        unique case (op.src)
            mcif_pkg::SRC_IH0: opnd = r_ih[0];
            mcif_pkg::SRC_IH1: opnd = r_ih[1];
            mcif_pkg::SRC_IH2: opnd = r_ih[2];
            mcif_pkg::SRC_IH3: opnd = r_ih[3];
            mcif_pkg::SRC_OH0: opnd = r_oh[0];
            mcif_pkg::SRC_OH1: opnd = r_oh[1];
            mcif_pkg::SRC_OH2: opnd = r_oh[2];
            mcif_pkg::SRC_OH3: opnd = r_oh[3];
            mcif_pkg::SRC_Y:   opnd = r_y;
            mcif_pkg::SRC_T:   opnd = r_t;
            mcif_pkg::SRC_V:   opnd = r_v;
            mcif_pkg::SRC_U:   opnd = r_u;
            default:           opnd = r_y;
        endcase
        unique case (op.coef)
            mcif_pkg::CF_A:  coef = r_ca;
            mcif_pkg::CF_B:  coef = r_cb;
            mcif_pkg::CF_C:  coef = r_cc;
            mcif_pkg::CF_D:  coef = r_cd;
            mcif_pkg::CF_E:  coef = r_ce;
            mcif_pkg::CF_G:  coef = r_gg;
            mcif_pkg::CF_G1: coef = $signed(r_gfb[31:0]);
            mcif_pkg::CF_G2: coef = $signed(r_gfb[63:32]);
            default:         coef = r_ca;
        endcase
        mac_ctl.en    = (r_state == mcif_pkg::S_EXEC);
        mac_ctl.phase = r_ph;
        mac_ctl.kind  = op.kind;
        mac_ctl.neg   = op.neg;
        mac_ctl.dbl   = op.dbl;
        mac_ctl.clear = ((r_state == mcif_pkg::S_LOAD) && (r_j == 3'd4))
                     || ((r_state == mcif_pkg::S_EXEC) && (r_ph == mcif_pkg::PH_ACC)
                         && (op.save != mcif_pkg::SV_NONE));
    end

    mcif_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_coef (coef),
        .i_opnd (opnd),
        .o_sum  (sum)
    );

    assign sum_sat = mcif_pkg::sat40(sum);

    always_comb begin
        rsum = (HW + 1)'(r_y) + (HW + 1)'(128);
        rsh  = rsum >>> 8;
        if (rsh > (HW + 1)'(64'sd2147483647)) begin
            y_out = 32'sh7FFFFFFF;
        end else if (rsh < -(HW + 1)'(64'sd2147483648)) begin
            y_out = 32'sh80000000;
        end else begin
            y_out = rsh[mcif_pkg::OUT_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mcif_pkg::S_CLR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = mcif_pkg::S_IDLE;
                end
            end
            mcif_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = oor ? mcif_pkg::S_OUT : mcif_pkg::S_SEC;
                end
            end
            mcif_pkg::S_SEC: begin
                priority if (sec_done) begin
                    n_state = mcif_pkg::S_OUT;
                end else if (active) begin
                    n_state = mcif_pkg::S_LOAD;
                end else begin
                    n_state = mcif_pkg::S_WB;
                end
            end
            mcif_pkg::S_LOAD: begin
                if (r_j == 3'd4) begin
                    n_state = mcif_pkg::S_EXEC;
                end
            end
            mcif_pkg::S_EXEC: begin
                if (r_ph == mcif_pkg::PH_ACC && op.last) begin
                    n_state = mcif_pkg::S_COMMIT;
                end
            end
            mcif_pkg::S_COMMIT: n_state = mcif_pkg::S_WB;
            mcif_pkg::S_WB: begin
                if (r_j == 3'd3) begin
                    n_state = mcif_pkg::S_SEC;
                end
            end
            mcif_pkg::S_OUT: begin
                if (!i_stall) begin
                    n_state = mcif_pkg::S_IDLE;
                end
            end
            default: n_state = mcif_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcif_pkg::S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
            r_ca   <= '0;
            r_cb   <= '0;
            r_cc   <= '0;
            r_cd   <= '0;
            r_ce   <= '0;
            r_gg   <= '0;
            r_gfb  <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                mcif_pkg::REG_MODE:      r_mode <= pwdata[1:0];
                mcif_pkg::REG_COEF_A:    r_ca   <= $signed(pwdata[31:0]);
                mcif_pkg::REG_COEF_B:    r_cb   <= $signed(pwdata[31:0]);
                mcif_pkg::REG_COEF_C:    r_cc   <= $signed(pwdata[31:0]);
                mcif_pkg::REG_COEF_D:    r_cd   <= $signed(pwdata[31:0]);
                mcif_pkg::REG_COEF_E:    r_ce   <= $signed(pwdata[31:0]);
                mcif_pkg::REG_GALV_GAIN: r_gg   <= $signed(pwdata[31:0]);
                mcif_pkg::REG_GALV_FB:   r_gfb  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            mcif_pkg::REG_MODE:      prdata = {62'd0, r_mode};
            mcif_pkg::REG_COEF_A:    prdata = {32'd0, r_ca};
            mcif_pkg::REG_COEF_B:    prdata = {32'd0, r_cb};
            mcif_pkg::REG_COEF_C:    prdata = {32'd0, r_cc};
            mcif_pkg::REG_COEF_D:    prdata = {32'd0, r_cd};
            mcif_pkg::REG_COEF_E:    prdata = {32'd0, r_ce};
            mcif_pkg::REG_GALV_GAIN: prdata = {32'd0, r_gg};
            mcif_pkg::REG_GALV_FB:   prdata = r_gfb;
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_state == mcif_pkg::S_CLR) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mcif_pkg::S_IDLE: begin
                if (in_xfer) begin
                    r_restart <= i_restart;
                    r_base    <= RW'(int'(i_channel) * SECTIONS);
                    r_sec     <= '0;
                    r_y       <= HW'(i_sample) <<< 8;
                    r_out     <= mcif_pkg::OUT_W'(i_sample);
                end
            end
            mcif_pkg::S_SEC: begin
                r_j <= '0;
                if (sec_done) begin
                    r_out <= y_out;
                end else if (!active) begin
                    for (int k = 0; k < 4; k++) begin
                        r_ih[k] <= '0;
                        r_oh[k] <= '0;
                    end
                end
            end
            mcif_pkg::S_LOAD: begin
                r_j <= r_j + 3'd1;
                if (r_j != 3'd0) begin
                    r_ih[ld_idx] <= r_restart ? '0 : r_ih_rd;
                    r_oh[ld_idx] <= r_restart ? '0 : r_oh_rd;
                end
                r_pc <= '0;
                r_ph <= mcif_pkg::PH_LO;
            end
            mcif_pkg::S_EXEC: begin
                unique case (r_ph)
                    mcif_pkg::PH_LO: r_ph <= mcif_pkg::PH_HI;
                    mcif_pkg::PH_HI: r_ph <= mcif_pkg::PH_ACC;
                    default: begin
                        r_ph <= mcif_pkg::PH_LO;
                        r_pc <= r_pc + 4'd1;
                        unique case (op.save)
                            mcif_pkg::SV_T: r_t <= sum_sat;
                            mcif_pkg::SV_V: r_v <= sum_sat;
                            mcif_pkg::SV_U: r_u <= sum_sat;
                            default: ;
                        endcase
                    end
                endcase
            end
            mcif_pkg::S_COMMIT: begin
                r_j <= '0;
                if (sim) begin
                    r_ih[0] <= r_y;
                    r_ih[1] <= r_ih[0];
                    r_oh[0] <= r_v;
                    r_oh[1] <= r_oh[0];
                    r_oh[2] <= r_u;
                    r_oh[3] <= r_oh[2];
                    r_y     <= r_u;
                end else begin
                    r_ih[0] <= r_y;
                    r_ih[1] <= r_ih[0];
                    r_ih[2] <= r_ih[1];
                    r_ih[3] <= r_ih[2];
                    r_oh[0] <= r_v;
                    r_oh[1] <= r_oh[0];
                    r_oh[2] <= r_oh[1];
                    r_oh[3] <= r_oh[2];
                    r_y     <= r_v;
                end
            end
            mcif_pkg::S_WB: begin
                r_j <= r_j + 3'd1;
                if (r_j == 3'd3) begin
                    r_sec <= r_sec + SW'(1);
                end
            end
            default: ;
        endcase
    end

endmodule

### src/mcif_chk.sv
`timescale 1ns / 1ps
module mcif_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_filtered
);

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("no stall after input transfer");

    a_stall_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |=> !o_valid)
        else $error("result repeated after transfer");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_filtered)))
        else $error("stalled result changed");

endmodule

bind multichannel_cascaded_iir_filter mcif_chk u_mcif_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_filtered (o_filtered)
);
